// File: rtl/core/lcc_pkg.sv
// Shared constants, codes and controller/datapath handshake types for the contact finder.
`default_nettype none

package lcc_pkg;

    // Chain storage sizing.
    localparam int MAX_RESIDUES = 16;
    localparam int IDX_W = $clog2(MAX_RESIDUES);
    localparam int CNT_W = $clog2(MAX_RESIDUES + 1);
    localparam int COORD_W = 6;
    localparam int DIST_W = 8;

    // At most this many result beats per item: one placement plus the contacts.
    localparam int MAX_RESULTS = 40;
    localparam int NCONT_W = $clog2(MAX_RESULTS);
    localparam logic [NCONT_W-1:0] CONTACT_LIMIT = NCONT_W'(MAX_RESULTS - 1);

    // Pair spacing rules for contacts.
    localparam logic [CNT_W-1:0] MIN_SEPARATION = CNT_W'(3);
    localparam logic [CNT_W-1:0] SEPARATION_STEP = CNT_W'(2);

    // Configuration register indexes.
    localparam logic CFG_DIMENSION = 1'b0;
    localparam logic CFG_CHAIN_LENGTH = 1'b1;

    // Dimension code that selects the 3D lattice.
    localparam logic [1:0] DIM_3D = 2'd3;

    // Result status codes.
    localparam logic [2:0] RES_STORED = 3'd0;
    localparam logic [2:0] RES_CLASH = 3'd1;
    localparam logic [2:0] RES_FULL = 3'd2;
    localparam logic [2:0] RES_CONTACT = 3'd3;
    localparam logic [2:0] RES_STARTED = 3'd4;

    // Input kind codes.
    localparam logic KIND_PLACE = 1'b0;
    localparam logic KIND_START = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_CLASH,
        ST_LOAD_I,
        ST_SCAN_J,
        ST_SEND_LAST
    } lcc_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic in_ready;
        logic start_chain;
        logic pend_full;
        logic pend_clash;
        logic store;
        logic a_clear;
        logic a_inc;
        logic b_from_a;
        logic b_step;
        logic use_b;
        logic pend_contact;
        logic cont_clear;
        logic emit;
        logic emit_last;
    } lcc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_valid;
        logic kind;
        logic full;
        logic hit;
        logic scan_end;
        logic final_store;
        logic i_done;
        logic j_end;
        logic contact;
        logic cont_limit;
        logic out_free;
    } lcc_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/lcc_item_if.sv
// Input item channel: valid/ready handshake with the placement request payload.
`default_nettype none

interface lcc_item_if;
    logic valid;
    logic ready;
    logic kind;
    logic signed [lcc_pkg::COORD_W-1:0] coord_x;
    logic signed [lcc_pkg::COORD_W-1:0] coord_y;
    logic signed [lcc_pkg::COORD_W-1:0] coord_z;

    modport source (output valid, output kind, output coord_x, output coord_y,
                    output coord_z, input ready);
    modport sink (input valid, input kind, input coord_x, input coord_y,
                  input coord_z, output ready);
endinterface

`default_nettype wire

// File: rtl/core/lcc_result_if.sv
// Result channel: valid/ready handshake with the status and contact payload.
`default_nettype none

interface lcc_result_if;
    logic valid;
    logic ready;
    logic [2:0] status;
    logic [lcc_pkg::CNT_W-1:0] residue_index;
    logic [lcc_pkg::IDX_W-1:0] contact_first;
    logic [lcc_pkg::IDX_W-1:0] contact_second;
    logic last;

    modport source (output valid, output status, output residue_index,
                    output contact_first, output contact_second, output last,
                    input ready);
    modport sink (input valid, input status, input residue_index,
                  input contact_first, input contact_second, input last,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/core/lcc_setup_if.sv
// Configuration write channel: valid/ready handshake with register index and data.
`default_nettype none

interface lcc_setup_if;
    logic valid;
    logic ready;
    logic index;
    logic [4:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/lattice_chain_contact_finder_unit.sv
// A start or full-chain item sets its pending result in the dispatch state and loads the
// result register from the send-last state once it is free. The clash scan compares one
// stored residue per cycle. The final placement adds the contact scan through the single
// store read port: residue i is latched in a load state and its odd partners j go one per cycle.
// One item is worked at a time; result back-pressure stalls the scan only when a beat waits.
// Reset (rst_n, asynchronous, active low) sets dimension 2, chain length 16, one placed residue.
`default_nettype none

module lattice_chain_contact_finder_unit (
    input  logic         clk,
    input  logic         rst_n,
    lcc_item_if.sink     item,
    lcc_result_if.source result,
    lcc_setup_if.sink    setup
);

    lcc_pkg::lcc_cmd_t  cmd;
    lcc_pkg::lcc_stat_t stat;

    // Sequencing.
    lcc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    // Storage, compare logic and channels.
    lcc_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result),
        .setup  (setup),
        .cmd    (cmd),
        .stat   (stat)
    );

endmodule

`default_nettype wire

// File: rtl/core/lcc_ctrl.sv
// Controller state machine: sequences the clash scan, the contact scan and result beats.
`default_nettype none

module lcc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  lcc_pkg::lcc_stat_t stat,
    output lcc_pkg::lcc_cmd_t  cmd
);

    lcc_pkg::lcc_state_t state_reg;
    lcc_pkg::lcc_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lcc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            lcc_pkg::ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (stat.in_valid)
                begin
                    state_next = lcc_pkg::ST_DISPATCH;
                end
            end

            lcc_pkg::ST_DISPATCH:
            begin
                if (stat.kind == lcc_pkg::KIND_START)
                begin
                    cmd.start_chain = 1'b1;
                    state_next = lcc_pkg::ST_SEND_LAST;
                end
                else if (stat.full)
                begin
                    cmd.pend_full = 1'b1;
                    state_next = lcc_pkg::ST_SEND_LAST;
                end
                else
                begin
                    cmd.a_clear = 1'b1;
                    state_next = lcc_pkg::ST_CLASH;
                end
            end

            // One stored residue is compared per cycle.
            lcc_pkg::ST_CLASH:
            begin
                if (stat.hit)
                begin
                    cmd.pend_clash = 1'b1;
                    state_next = lcc_pkg::ST_SEND_LAST;
                end
                else if (stat.scan_end)
                begin
                    cmd.store = 1'b1;
                    if (stat.final_store)
                    begin
                        cmd.a_clear = 1'b1;
                        cmd.cont_clear = 1'b1;
                        state_next = lcc_pkg::ST_LOAD_I;
                    end
                    else
                    begin
                        state_next = lcc_pkg::ST_SEND_LAST;
                    end
                end
                else
                begin
                    cmd.a_inc = 1'b1;
                end
            end

            // Latch residue i and point j at the first candidate partner.
            lcc_pkg::ST_LOAD_I:
            begin
                if (stat.i_done)
                begin
                    state_next = lcc_pkg::ST_SEND_LAST;
                end
                else
                begin
                    cmd.b_from_a = 1'b1;
                    state_next = lcc_pkg::ST_SCAN_J;
                end
            end

            // A found contact pushes the previous result out with last clear.
            lcc_pkg::ST_SCAN_J:
            begin
                cmd.use_b = 1'b1;
                if (stat.contact && stat.cont_limit)
                begin
                    state_next = lcc_pkg::ST_SEND_LAST;
                end
                else if (!stat.contact || stat.out_free)
                begin
                    if (stat.contact)
                    begin
                        cmd.emit = 1'b1;
                        cmd.pend_contact = 1'b1;
                    end
                    if (stat.j_end)
                    begin
                        cmd.a_inc = 1'b1;
                        state_next = lcc_pkg::ST_LOAD_I;
                    end
                    else
                    begin
                        cmd.b_step = 1'b1;
                    end
                end
            end

            lcc_pkg::ST_SEND_LAST:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.emit_last = 1'b1;
                    state_next = lcc_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = lcc_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    // A contact is only recorded from the pair scan.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pend_contact |-> state_reg == lcc_pkg::ST_SCAN_J)
        else $error("contact recorded outside the pair scan");

    // Leaving the final beat always returns to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_last |=> state_reg == lcc_pkg::ST_IDLE)
        else $error("final beat did not return to idle");

    // A stored residue always follows a clean clash scan.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |-> !stat.hit && stat.scan_end)
        else $error("residue stored without a clean clash scan");
`endif

endmodule

`default_nettype wire

// File: rtl/core/lcc_datapath.sv
// Datapath: configuration, residue position store, scan indexes, compare logic and result register.
`default_nettype none

module lcc_datapath (
    input  logic               clk,
    input  logic               rst_n,
    lcc_item_if.sink           item,
    lcc_result_if.source       result,
    lcc_setup_if.sink          setup,
    input  lcc_pkg::lcc_cmd_t  cmd,
    output lcc_pkg::lcc_stat_t stat
);

    localparam int IW = lcc_pkg::IDX_W;
    localparam int CW = lcc_pkg::CNT_W;
    localparam int PW = lcc_pkg::COORD_W;
    localparam int NW = lcc_pkg::NCONT_W;
    localparam int DW = lcc_pkg::DIST_W;
    localparam int DEPTH = lcc_pkg::MAX_RESIDUES;

    // Configuration and chain state.
    logic [1:0]    dim_reg;
    logic [CW-1:0] len_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [NW-1:0] ncont_reg;
    logic [NW-1:0] ncont_next;
    logic          out_valid_reg;
    logic          out_valid_next;

    // Position store; entry 0 is the origin and is never written.
    logic signed [PW-1:0] pos_x_mem [DEPTH];
    logic signed [PW-1:0] pos_y_mem [DEPTH];
    logic signed [PW-1:0] pos_z_mem [DEPTH];

    // Latched request and scan registers.
    logic                 kind_reg;
    logic signed [PW-1:0] cx_reg;
    logic signed [PW-1:0] cy_reg;
    logic signed [PW-1:0] cz_reg;
    logic [IW-1:0]        idx_a_reg;
    logic [IW-1:0]        idx_a_next;
    logic [CW-1:0]        idx_b_reg;
    logic [CW-1:0]        idx_b_next;
    logic signed [PW-1:0] ref_x_reg;
    logic signed [PW-1:0] ref_y_reg;
    logic signed [PW-1:0] ref_z_reg;

    // Pending result and output register payload.
    logic [2:0]    pend_status_reg;
    logic [CW-1:0] pend_index_reg;
    logic [IW-1:0] pend_first_reg;
    logic [IW-1:0] pend_second_reg;
    logic [2:0]    out_status_reg;
    logic [CW-1:0] out_index_reg;
    logic [IW-1:0] out_first_reg;
    logic [IW-1:0] out_second_reg;
    logic          out_last_reg;

    logic                 take;
    logic                 three;
    logic [CW-1:0]        len_eff;
    logic [IW-1:0]        rd_addr;
    logic signed [PW-1:0] rd_x;
    logic signed [PW-1:0] rd_y;
    logic signed [PW-1:0] rd_z;
    logic [DW-1:0]        lat_gap;

    function automatic logic [DW-1:0] abs_diff(input logic signed [PW-1:0] a,
                                               input logic signed [PW-1:0] b);
        logic signed [PW:0] d;
        d = {a[PW-1], a} - {b[PW-1], b};
        abs_diff = d[PW] ? DW'(-d) : DW'(d);
    endfunction

    assign take = item.valid && cmd.in_ready;
    assign item.ready = cmd.in_ready;
    assign setup.ready = 1'b1;
    assign three = (dim_reg == lcc_pkg::DIM_3D);
    assign len_eff = (len_reg > CW'(DEPTH)) ? CW'(DEPTH) : len_reg;

    // Single read port shared by the clash scan, residue i and residue j.
    assign rd_addr = cmd.use_b ? idx_b_reg[IW-1:0] : idx_a_reg;
    assign rd_x = (rd_addr == '0) ? '0 : pos_x_mem[rd_addr];
    assign rd_y = (rd_addr == '0) ? '0 : pos_y_mem[rd_addr];
    assign rd_z = (rd_addr == '0) ? '0 : pos_z_mem[rd_addr];

    // Lattice distance between residue i and residue j.
    assign lat_gap = abs_diff(ref_x_reg, rd_x) + abs_diff(ref_y_reg, rd_y)
                   + (three ? abs_diff(ref_z_reg, rd_z) : DW'(0));

    // Status toward the controller.
    always_comb
    begin
        stat.in_valid = item.valid;
        stat.kind = kind_reg;
        stat.full = (count_reg >= len_eff);
        stat.hit = (rd_x == cx_reg) && (rd_y == cy_reg) && (!three || rd_z == cz_reg);
        stat.scan_end = ({1'b0, idx_a_reg} + CW'(1)) == count_reg;
        stat.final_store = (count_reg + CW'(1)) == len_eff;
        stat.i_done = ({1'b0, idx_a_reg} + lcc_pkg::MIN_SEPARATION) >= len_eff;
        stat.j_end = (idx_b_reg + lcc_pkg::SEPARATION_STEP) >= len_eff;
        stat.contact = (lat_gap == DW'(1));
        stat.cont_limit = (ncont_reg == lcc_pkg::CONTACT_LIMIT);
        stat.out_free = !out_valid_reg || result.ready;
    end

    // Next values of the control registers.
    always_comb
    begin
        count_next = count_reg;
        if (cmd.start_chain)
        begin
            count_next = CW'(1);
        end
        else if (cmd.store)
        begin
            count_next = count_reg + CW'(1);
        end

        ncont_next = ncont_reg;
        if (cmd.cont_clear)
        begin
            ncont_next = '0;
        end
        else if (cmd.pend_contact)
        begin
            ncont_next = ncont_reg + NW'(1);
        end

        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end

        idx_a_next = idx_a_reg;
        if (cmd.a_clear)
        begin
            idx_a_next = '0;
        end
        else if (cmd.a_inc)
        begin
            idx_a_next = idx_a_reg + IW'(1);
        end

        idx_b_next = idx_b_reg;
        if (cmd.b_from_a)
        begin
            idx_b_next = {1'b0, idx_a_reg} + lcc_pkg::MIN_SEPARATION;
        end
        else if (cmd.b_step)
        begin
            idx_b_next = idx_b_reg + lcc_pkg::SEPARATION_STEP;
        end
    end

    // Control registers and configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg <= 2'd2;
            len_reg <= CW'(DEPTH);
            count_reg <= CW'(1);
            ncont_reg <= '0;
            out_valid_reg <= 1'b0;
            idx_a_reg <= '0;
            idx_b_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            ncont_reg <= ncont_next;
            out_valid_reg <= out_valid_next;
            idx_a_reg <= idx_a_next;
            idx_b_reg <= idx_b_next;
            if (setup.valid)
            begin
                case (setup.index)
                    lcc_pkg::CFG_DIMENSION:    dim_reg <= setup.data[1:0];
                    lcc_pkg::CFG_CHAIN_LENGTH: len_reg <= setup.data;
                    default:                   ;
                endcase
            end
        end
    end

    // Position store writes.
    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            pos_x_mem[count_reg[IW-1:0]] <= cx_reg;
            pos_y_mem[count_reg[IW-1:0]] <= cy_reg;
            pos_z_mem[count_reg[IW-1:0]] <= cz_reg;
        end
    end

    // Request latch, residue i latch, pending result and output payload.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            kind_reg <= item.kind;
            cx_reg <= item.coord_x;
            cy_reg <= item.coord_y;
            cz_reg <= item.coord_z;
        end

        if (cmd.b_from_a)
        begin
            ref_x_reg <= rd_x;
            ref_y_reg <= rd_y;
            ref_z_reg <= rd_z;
        end

        if (cmd.start_chain)
        begin
            pend_status_reg <= lcc_pkg::RES_STARTED;
            pend_index_reg <= '0;
            pend_first_reg <= '0;
            pend_second_reg <= '0;
        end
        else if (cmd.pend_full || cmd.pend_clash)
        begin
            pend_status_reg <= cmd.pend_full ? lcc_pkg::RES_FULL : lcc_pkg::RES_CLASH;
            pend_index_reg <= count_reg;
            pend_first_reg <= '0;
            pend_second_reg <= '0;
        end
        else if (cmd.store)
        begin
            pend_status_reg <= lcc_pkg::RES_STORED;
            pend_index_reg <= count_reg;
            pend_first_reg <= '0;
            pend_second_reg <= '0;
        end
        else if (cmd.pend_contact)
        begin
            pend_status_reg <= lcc_pkg::RES_CONTACT;
            pend_index_reg <= '0;
            pend_first_reg <= idx_a_reg;
            pend_second_reg <= idx_b_reg[IW-1:0];
        end

        if (cmd.emit)
        begin
            out_status_reg <= pend_status_reg;
            out_index_reg <= pend_index_reg;
            out_first_reg <= pend_first_reg;
            out_second_reg <= pend_second_reg;
            out_last_reg <= cmd.emit_last;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.status = out_status_reg;
    assign result.residue_index = out_index_reg;
    assign result.contact_first = out_first_reg;
    assign result.contact_second = out_second_reg;
    assign result.last = out_last_reg;

`ifndef NO_ASSERTIONS
    // The placed count stays within one residue and the store depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg >= CW'(1) && count_reg <= CW'(DEPTH))
        else $error("placed count out of range");

    // A new beat never overwrites one that is still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !out_valid_reg || result.ready)
        else $error("result beat overwritten");

    // A store never targets the origin entry or runs past the depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |-> count_reg != '0 && count_reg < CW'(DEPTH))
        else $error("store outside the residue range");

    // The contact counter never passes the result limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        ncont_reg <= lcc_pkg::CONTACT_LIMIT)
        else $error("contact count above the result limit");
`endif

endmodule

`default_nettype wire

// File: tb/tb_lattice_chain_contact_finder_unit.sv
// Self-checking testbench for the lattice chain contact finder: placement, clashes and contacts.
module tb_lattice_chain_contact_finder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import lcc_pkg::*;

    // Cycles without any accepted beat before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 4000;
    // Quiet cycles after the last result before a register write or the end.
    localparam int SETTLE_CYCLES = 8;
    // Length of the long result hold-off in the stall test.
    localparam int STALL_CYCLES = 400;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [CNT_W-1:0] residue_index;
        logic [IDX_W-1:0] contact_first;
        logic [IDX_W-1:0] contact_second;
        logic             last;
    } result_beat_t;

    logic clk;
    logic rst_n;

    lcc_item_if   item_bus ();
    lcc_result_if result_bus ();
    lcc_setup_if  setup_bus ();

    lattice_chain_contact_finder_unit i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (result_bus),
        .setup  (setup_bus)
    );

    // Predicted chain: its own copy of the registers and the residue positions.
    logic [1:0]       chain_dim;
    logic [4:0]       chain_len;
    coord_t           chain_x [MAX_RESIDUES];
    coord_t           chain_y [MAX_RESIDUES];
    coord_t           chain_z [MAX_RESIDUES];
    int unsigned      chain_count;

    // Results predicted but not yet seen on the result channel.
    result_beat_t     pending_results [$];
    result_beat_t     want_beat;

    int               errors;
    int               idle_cycles;
    int               hold_off;
    bit               steady;

    // Free-running clock, 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result receiver: random stalls, a counted hold-off, or always ready.
    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            result_bus.ready <= 1'b0;
            hold_off--;
        end
        else if (steady)
            result_bus.ready <= 1'b1;
        else
            result_bus.ready <= ($urandom_range(99) >= 35);
    end

    // Compare each accepted result beat against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result beat, expected none, got status %0d",
                         $time, result_bus.status);
                errors++;
            end
            else
            begin
                want_beat = pending_results.pop_front();
                check_field("status", want_beat.status, result_bus.status);
                check_field("residue_index", want_beat.residue_index,
                            result_bus.residue_index);
                check_field("contact_first", want_beat.contact_first,
                            result_bus.contact_first);
                check_field("contact_second", want_beat.contact_second,
                            result_bus.contact_second);
                check_field("last", want_beat.last, result_bus.last);
            end
        end
    end

    // Watchdog: end the run when no beat moves on any channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (item_bus.valid && item_bus.ready) ||
            (result_bus.valid && result_bus.ready) ||
            (setup_bus.valid && setup_bus.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no beat accepted for %0d cycles", $time, idle_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: mismatch on %s, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Empty the chain: only residue 0 at the origin remains.
    task automatic clear_chain();
        for (int k = 0; k < MAX_RESIDUES; k++)
        begin
            chain_x[k] = '0;
            chain_y[k] = '0;
            chain_z[k] = '0;
        end
        chain_count = 1;
    endtask

    function automatic int lattice_gap(input coord_t a, input coord_t b);
        int d;
        d = int'(a) - int'(b);
        return (d < 0) ? -d : d;
    endfunction

    function automatic int unsigned effective_length();
        return (chain_len > MAX_RESIDUES) ? MAX_RESIDUES : chain_len;
    endfunction

    // True when a placed residue already sits on this lattice site.
    function automatic bit site_taken(input coord_t cx, input coord_t cy, input coord_t cz);
        for (int k = 0; k < chain_count && k < MAX_RESIDUES; k++)
            if (chain_x[k] == cx && chain_y[k] == cy &&
                (chain_dim != DIM_3D || chain_z[k] == cz))
                return 1'b1;
        return 1'b0;
    endfunction

    // Work out the result beats of one accepted item and queue them.
    task automatic predict_item(input logic kind, input coord_t cx, input coord_t cy,
                                input coord_t cz);
        result_beat_t beats [MAX_RESULTS];
        int           n;
        int           d;
        int unsigned  len;
        int unsigned  i;
        int unsigned  j;
        len = effective_length();
        n = 0;
        if (kind == KIND_START)
        begin
            clear_chain();
            beats[0] = '{RES_STARTED, '0, '0, '0, 1'b0};
            n = 1;
        end
        else if (chain_count >= len)
        begin
            beats[0] = '{RES_FULL, CNT_W'(chain_count), '0, '0, 1'b0};
            n = 1;
        end
        else if (site_taken(cx, cy, cz))
        begin
            beats[0] = '{RES_CLASH, CNT_W'(chain_count), '0, '0, 1'b0};
            n = 1;
        end
        else
        begin
            chain_x[chain_count] = cx;
            chain_y[chain_count] = cy;
            chain_z[chain_count] = cz;
            beats[0] = '{RES_STORED, CNT_W'(chain_count), '0, '0, 1'b0};
            n = 1;
            chain_count++;
            // The final residue triggers the scan over odd separations of three or more.
            if (chain_count == len)
            begin
                for (i = 0; i < len; i++)
                begin
                    for (j = i + 3; j < len; j += 2)
                    begin
                        d = lattice_gap(chain_x[i], chain_x[j]) +
                            lattice_gap(chain_y[i], chain_y[j]);
                        if (chain_dim == DIM_3D)
                            d += lattice_gap(chain_z[i], chain_z[j]);
                        if (d == 1 && n < MAX_RESULTS)
                        begin
                            beats[n] = '{RES_CONTACT, '0, IDX_W'(i), IDX_W'(j), 1'b0};
                            n++;
                        end
                    end
                end
            end
        end
        for (int k = 0; k < n; k++)
        begin
            beats[k].last = (k == n - 1);
            pending_results.insert(pending_results.size(), beats[k]);
        end
    endtask

    // Send one item beat; returns at the falling edge after acceptance.
    task automatic send_item(input logic kind, input coord_t cx, input coord_t cy,
                             input coord_t cz);
        while (!steady && $urandom_range(99) < 35)
        begin
            item_bus.valid <= 1'b0;
            @(negedge clk);
        end
        item_bus.valid   <= 1'b1;
        item_bus.kind    <= kind;
        item_bus.coord_x <= cx;
        item_bus.coord_y <= cy;
        item_bus.coord_z <= cz;
        do
            @(posedge clk);
        while (!item_bus.ready);
        predict_item(kind, cx, cy, cz);
        @(negedge clk);
    endtask

    // Drop the item valid and wait until every predicted result has been seen.
    task automatic wait_drained();
        item_bus.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write one configuration register once the block is idle.
    task automatic write_reg(input logic index, input logic [4:0] value);
        wait_drained();
        setup_bus.valid <= 1'b1;
        setup_bus.index <= index;
        setup_bus.data  <= value;
        do
            @(posedge clk);
        while (!setup_bus.ready);
        if (index == CFG_DIMENSION)
            chain_dim = value[1:0];
        else
            chain_len = value;
        @(negedge clk);
        setup_bus.valid <= 1'b0;
    endtask

    function automatic coord_t rand_coord();
        return coord_t'(int'($urandom_range(32)) - 16);
    endfunction

    // Pick the next item: mostly a self-avoiding step from the chain end, plus
    // clashes, starts, refused places and random noise.
    task automatic pick_item(output logic kind, output coord_t cx, output coord_t cy,
                             output coord_t cz);
        int     roll;
        int     dirs;
        int     first_dir;
        int     d;
        int     k;
        coord_t ex;
        coord_t ey;
        coord_t ez;
        bit     found;
        roll = $urandom_range(99);
        kind = KIND_PLACE;
        cx = rand_coord();
        cy = rand_coord();
        cz = rand_coord();
        if (roll < 6)
            kind = KIND_START;
        else if (roll < 14)
            ;
        else if (roll < 24)
        begin
            // Land on a residue already placed.
            k = $urandom_range(chain_count - 1);
            cx = chain_x[k];
            cy = chain_y[k];
            if (chain_dim == DIM_3D)
                cz = chain_z[k];
        end
        else if (chain_count >= effective_length())
        begin
            if ($urandom_range(3) != 0)
                kind = KIND_START;
        end
        else
        begin
            dirs = (chain_dim == DIM_3D) ? 6 : 4;
            first_dir = $urandom_range(dirs - 1);
            found = 1'b0;
            for (int t = 0; t < dirs && !found; t++)
            begin
                d = (first_dir + t) % dirs;
                ex = chain_x[chain_count - 1];
                ey = chain_y[chain_count - 1];
                ez = (chain_dim == DIM_3D) ? chain_z[chain_count - 1] : cz;
                case (d)
                    0: ex = ex + 1;
                    1: ex = ex - 1;
                    2: ey = ey + 1;
                    3: ey = ey - 1;
                    4: ez = ez + 1;
                    default: ez = ez - 1;
                endcase
                if (!site_taken(ex, ey, ez))
                begin
                    found = 1'b1;
                    cx = ex;
                    cy = ey;
                    cz = ez;
                end
            end
            // A walk boxed in by its own residues starts over.
            if (!found)
                kind = KIND_START;
        end
    endtask

    task automatic run_random_phase(input logic [1:0] dim, input logic [4:0] len,
                                    input int items);
        logic   kind;
        coord_t cx;
        coord_t cy;
        coord_t cz;
        write_reg(CFG_DIMENSION, {3'($urandom), dim});
        write_reg(CFG_CHAIN_LENGTH, len);
        repeat (items)
        begin
            pick_item(kind, cx, cy, cz);
            send_item(kind, cx, cy, cz);
        end
    endtask

    // Reset settings: 2D ignores z for clashes, coordinate extremes are stored.
    task automatic test_default_setup();
        send_item(KIND_PLACE, 6'sd1, 6'sd0, -6'sd16);
        send_item(KIND_PLACE, 6'sd0, 6'sd0, 6'sd16);
        send_item(KIND_PLACE, -6'sd16, -6'sd16, -6'sd16);
        send_item(KIND_PLACE, 6'sd16, 6'sd16, 6'sd16);
        send_item(KIND_START, 6'sd15, -6'sd1, 6'sd5);
    endtask

    // Short, zero, unit and saturated chain lengths, with refused places.
    task automatic test_short_and_saturated_lengths();
        write_reg(CFG_CHAIN_LENGTH, 5'd2);
        send_item(KIND_PLACE, 6'sd0, 6'sd1, 6'sd0);
        send_item(KIND_PLACE, 6'sd0, -6'sd1, 6'sd0);
        write_reg(CFG_CHAIN_LENGTH, 5'd1);
        send_item(KIND_PLACE, 6'sd2, 6'sd0, 6'sd0);
        send_item(KIND_START, 6'sd0, 6'sd0, 6'sd0);
        send_item(KIND_PLACE, 6'sd1, 6'sd0, 6'sd0);
        write_reg(CFG_CHAIN_LENGTH, 5'd0);
        send_item(KIND_PLACE, 6'sd1, 6'sd0, 6'sd0);
        write_reg(CFG_CHAIN_LENGTH, 5'd31);
        send_item(KIND_PLACE, 6'sd1, 6'sd0, 6'sd0);
        send_item(KIND_START, 6'sd0, 6'sd0, 6'sd0);
    endtask

    // A unit square closes one contact between residues 0 and 3.
    task automatic test_square_contact_2d();
        write_reg(CFG_CHAIN_LENGTH, 5'd4);
        send_item(KIND_START, 6'sd0, 6'sd0, 6'sd0);
        send_item(KIND_PLACE, 6'sd1, 6'sd0, 6'sd7);
        send_item(KIND_PLACE, 6'sd1, 6'sd1, -6'sd7);
        send_item(KIND_PLACE, 6'sd0, 6'sd1, 6'sd3);
    endtask

    // 3D chain with a clash at the origin, two contacts and then a full chain.
    task automatic test_cube_contacts_3d();
        write_reg(CFG_DIMENSION, {3'b000, DIM_3D});
        write_reg(CFG_CHAIN_LENGTH, 5'd6);
        send_item(KIND_START, 6'sd0, 6'sd0, 6'sd0);
        send_item(KIND_PLACE, 6'sd0, 6'sd0, 6'sd0);
        send_item(KIND_PLACE, 6'sd1, 6'sd0, 6'sd0);
        send_item(KIND_PLACE, 6'sd1, 6'sd1, 6'sd0);
        send_item(KIND_PLACE, 6'sd0, 6'sd1, 6'sd0);
        send_item(KIND_PLACE, 6'sd0, 6'sd1, 6'sd1);
        send_item(KIND_PLACE, 6'sd0, 6'sd0, 6'sd1);
        send_item(KIND_PLACE, 6'sd2, 6'sd0, 6'sd0);
    endtask

    task automatic test_random_walks();
        run_random_phase(DIM_3D, 5'd16, 18);
        run_random_phase(2'd2, 5'd16, 18);
        run_random_phase(2'd1, 5'd7, 8);
        run_random_phase(DIM_3D, 5'd5, 6);
        run_random_phase(2'd0, 5'd3, 4);
        run_random_phase(DIM_3D, 5'd10, 8);
    endtask

    // Neither side idles for a whole stretch of items.
    task automatic test_back_to_back();
        steady = 1'b1;
        run_random_phase(2'd2, 5'd6, 12);
        wait_drained();
        steady = 1'b0;
    endtask

    // The receiver holds off while items keep coming, so the input stalls.
    task automatic test_result_stall();
        wait_drained();
        hold_off = STALL_CYCLES;
        run_random_phase(DIM_3D, 5'd8, 10);
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        item_bus.valid = 1'b0;
        item_bus.kind = KIND_PLACE;
        item_bus.coord_x = '0;
        item_bus.coord_y = '0;
        item_bus.coord_z = '0;
        setup_bus.valid = 1'b0;
        setup_bus.index = CFG_DIMENSION;
        setup_bus.data = '0;
        errors = 0;
        idle_cycles = 0;
        hold_off = 0;
        steady = 1'b0;
        chain_dim = 2'd2;
        chain_len = 5'd16;
        clear_chain();

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_default_setup();
        test_short_and_saturated_lengths();
        test_square_contact_2d();
        test_cube_contacts_3d();
        test_random_walks();
        test_back_to_back();
        test_result_stall();

        wait_drained();
        if (pending_results.size() != 0)
            errors++;
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
